/* rtl/tdma_sts_pkg.sv */
// Shared types and constants for the TDMA slot time scheduler.
package tdma_sts_pkg;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned SfW    = 30;
  localparam int unsigned LenW   = 16;
  localparam int unsigned CntW   = 8;
  localparam int unsigned ProdW  = LenW + CntW;
  localparam int unsigned NeedW  = ProdW + 1;
  localparam int unsigned RegIdxW = 3;

  localparam logic [TimeW-1:0] SUPERFRAME_MAX = 32'h3FFF_FFFF;

  typedef enum logic [1:0] {
    CMD_SYNC  = 2'd0,
    CMD_START = 2'd1,
    CMD_TICK  = 2'd2
  } cmd_e;

  typedef enum logic [RegIdxW-1:0] {
    REG_SUPERFRAME = 3'd0,
    REG_SLOT_LEN   = 3'd1,
    REG_BEACON_LEN = 3'd2,
    REG_SLOT_COUNT = 3'd3,
    REG_OWN_SLOT   = 3'd4,
    REG_GUARD      = 3'd5,
    REG_HOLDOVER   = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic [SfW-1:0]   superframe_len;
    logic [LenW-1:0]  slot_len;
    logic [LenW-1:0]  beacon_len;
    logic [CntW-1:0]  slot_count;
    logic [CntW-1:0]  own_slot;
    logic [LenW-1:0]  guard_time;
    logic [TimeW-1:0] holdover_time;
  } cfg_t;

  typedef struct packed {
    logic [1:0]       command;
    logic [TimeW-1:0] time_ms;
    logic [LenW-1:0]  air_ms;
  } in_item_t;

  typedef struct packed {
    logic [TimeW-1:0] next_tx_ms;
    logic [TimeW-1:0] next_beacon_ms;
    logic             epoch_valid;
    logic             synced;
    logic             config_invalid;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_CHK,
    ST_GO_B,
    ST_DIV_B,
    ST_GO_T,
    ST_DIV_T,
    ST_OUT
  } state_e;

endpackage

/* rtl/tdma_sts_cfg.sv */
// Configuration register file of the TDMA slot time scheduler.
module tdma_sts_cfg (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [tdma_sts_pkg::RegIdxW-1:0]  cfg_index_i,
  input  logic [tdma_sts_pkg::TimeW-1:0]    cfg_data_i,
  output tdma_sts_pkg::cfg_t                cfg_o
);

  tdma_sts_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (tdma_sts_pkg::reg_idx_e'(cfg_index_i))
        tdma_sts_pkg::REG_SUPERFRAME:
          cfg_d.superframe_len = cfg_data_i[tdma_sts_pkg::SfW-1:0];
        tdma_sts_pkg::REG_SLOT_LEN:   cfg_d.slot_len   = cfg_data_i[tdma_sts_pkg::LenW-1:0];
        tdma_sts_pkg::REG_BEACON_LEN: cfg_d.beacon_len = cfg_data_i[tdma_sts_pkg::LenW-1:0];
        tdma_sts_pkg::REG_SLOT_COUNT: cfg_d.slot_count = cfg_data_i[tdma_sts_pkg::CntW-1:0];
        tdma_sts_pkg::REG_OWN_SLOT:   cfg_d.own_slot   = cfg_data_i[tdma_sts_pkg::CntW-1:0];
        tdma_sts_pkg::REG_GUARD:      cfg_d.guard_time = cfg_data_i[tdma_sts_pkg::LenW-1:0];
        tdma_sts_pkg::REG_HOLDOVER:   cfg_d.holdover_time = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.superframe_len <= 30'd10000;
      cfg_q.slot_len       <= 16'd1000;
      cfg_q.beacon_len     <= 16'd1000;
      cfg_q.slot_count     <= 8'd8;
      cfg_q.own_slot       <= 8'd0;
      cfg_q.guard_time     <= 16'd50;
      cfg_q.holdover_time  <= 32'd60000;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

/* rtl/tdma_sts_rem.sv */
// Bit-serial restoring remainder unit: dividend mod superframe length.
module tdma_sts_rem (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [tdma_sts_pkg::TimeW-1:0]  dividend_i,
  input  logic [tdma_sts_pkg::SfW-1:0]    divisor_i,
  output logic                            busy_o,
  output logic                            done_o,
  output logic [tdma_sts_pkg::SfW-1:0]    rem_o
);

  localparam int unsigned StepW = $clog2(tdma_sts_pkg::TimeW);

  logic                           busy_q, busy_d;
  logic                           done_q, done_d;
  logic [StepW-1:0]               cnt_q, cnt_d;
  logic [tdma_sts_pkg::TimeW-1:0] dvd_q, dvd_d;
  logic [tdma_sts_pkg::SfW-1:0]   rem_q, rem_d;
  logic [tdma_sts_pkg::SfW:0]     rem_sh;
  logic [tdma_sts_pkg::SfW:0]     rem_sub;

  // one shift, compare and subtract per cycle
  assign rem_sh  = {rem_q, dvd_q[tdma_sts_pkg::TimeW-1]};
  assign rem_sub = rem_sh - {1'b0, divisor_i};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = dividend_i;
      rem_d  = '0;
    end else if (busy_q) begin
      dvd_d = {dvd_q[tdma_sts_pkg::TimeW-2:0], 1'b0};
      if (rem_sh >= {1'b0, divisor_i}) begin
        rem_d = rem_sub[tdma_sts_pkg::SfW-1:0];
      end else begin
        rem_d = rem_sh[tdma_sts_pkg::SfW-1:0];
      end
      cnt_d = cnt_q + StepW'(1);
      if (cnt_q == StepW'(tdma_sts_pkg::TimeW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

/* rtl/tdma_slot_time_scheduler.sv */
// Top level of the TDMA slot time scheduler: event sequencer and result register.
//
// Usage:
//  - Input channel (in_valid_i / in_ready_o / in_item_i) carries one event item:
//    beacon sync, free-run start, or tick/query (the unused code acts as tick).
//  - Output channel (out_valid_o / out_ready_i / out_item_o) returns one item
//    per event: next own transmit slot start, next beacon start, and flags.
//  - Config channel (cfg_valid_i / cfg_ready_o / cfg_index_i / cfg_data_i)
//    writes one register per handshake; it is always ready. Write only while
//    the block is idle.
//  - Sequence: after input acceptance the sequencer runs its setup and handoff
//    states and two 32-step remainder passes through the shared unit.
//    Without an epoch or with invalid registers the passes are skipped.
//  - One event at a time: a new item is taken only once the last one has left
//    the sequencer; in_ready_o is high only when the sequencer is idle.
//  - The finished item waits in an output register, so the next event may be
//    accepted while the receiver stalls; a further result holds in the final
//    sequencer step until the output register is taken.
//  - Reset: registers take their documented defaults, epoch and sync state
//    clear, no item is pending.
module tdma_slot_time_scheduler (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  tdma_sts_pkg::in_item_t            in_item_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output tdma_sts_pkg::out_item_t           out_item_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [tdma_sts_pkg::RegIdxW-1:0]  cfg_index_i,
  input  logic [tdma_sts_pkg::TimeW-1:0]    cfg_data_i
);

  localparam int unsigned TW = tdma_sts_pkg::TimeW;

  tdma_sts_pkg::cfg_t   cfg;
  tdma_sts_pkg::state_e state_q, state_d;

  // persistent scheduler state
  logic [TW-1:0] epoch_q, epoch_d;
  logic [TW-1:0] last_sync_q, last_sync_d;
  logic          known_q, known_d;
  logic          sync_q, sync_d;

  // per-event working registers
  logic [TW-1:0]                  target_q, target_d;
  logic [tdma_sts_pkg::ProdW-1:0] prod_own_q, prod_own_d;
  logic [tdma_sts_pkg::ProdW-1:0] prod_cnt_q, prod_cnt_d;
  logic                           bad_q, bad_d;
  logic [TW-1:0]                  base_t_q, base_t_d;
  logic [TW-1:0]                  d_b_q, d_b_d;
  logic [TW-1:0]                  d_t_q, d_t_d;
  logic [TW-1:0]                  bcn_q, bcn_d;
  logic [TW-1:0]                  tx_q, tx_d;

  tdma_sts_pkg::out_item_t out_q, out_d;
  logic                    out_valid_q, out_valid_d;

  logic                         rem_start;
  logic [TW-1:0]                rem_dvd;
  logic                         rem_busy;
  logic                         rem_done;
  logic [tdma_sts_pkg::SfW-1:0] rem_val;

  logic                           in_acc;
  logic [tdma_sts_pkg::NeedW-1:0] need;
  logic [TW-1:0]                  offset;
  logic [TW-1:0]                  hold_diff;

  tdma_sts_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  tdma_sts_rem u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start),
    .dividend_i (rem_dvd),
    .divisor_i  (cfg.superframe_len),
    .busy_o     (rem_busy),
    .done_o     (rem_done),
    .rem_o      (rem_val)
  );

  // First start not before target: base when already due (wrap-safe),
  // otherwise target rounded up to the superframe grid.
  function automatic logic [TW-1:0] first_start(
    input logic [TW-1:0]                base,
    input logic [TW-1:0]                target,
    input logic [TW-1:0]                diff,
    input logic [tdma_sts_pkg::SfW-1:0] rem,
    input logic [tdma_sts_pkg::SfW-1:0] sf
  );
    logic [TW-1:0] pad;
    pad = '0;
    if (rem != '0) begin
      pad = TW'(sf) - TW'(rem);
    end
    if (diff == '0 || diff[TW-1]) begin
      first_start = base;
    end else begin
      first_start = target + pad;
    end
  endfunction

  assign in_ready_o = (state_q == tdma_sts_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign hold_diff  = in_item_i.time_ms - last_sync_q;
  assign need       = tdma_sts_pkg::NeedW'(cfg.beacon_len) + tdma_sts_pkg::NeedW'(prod_cnt_q);
  assign offset     = TW'(cfg.beacon_len) + TW'(prod_own_q);

  always_comb begin
    state_d     = state_q;
    epoch_d     = epoch_q;
    last_sync_d = last_sync_q;
    known_d     = known_q;
    sync_d      = sync_q;
    target_d    = target_q;
    prod_own_d  = prod_own_q;
    prod_cnt_d  = prod_cnt_q;
    bad_d       = bad_q;
    base_t_d    = base_t_q;
    d_b_d       = d_b_q;
    d_t_d       = d_t_q;
    bcn_d       = bcn_q;
    tx_d        = tx_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    rem_start   = 1'b0;
    rem_dvd     = d_b_q;

    case (state_q)
      tdma_sts_pkg::ST_IDLE: begin
        if (in_acc) begin
          target_d = in_item_i.time_ms + TW'(cfg.guard_time);
          case (tdma_sts_pkg::cmd_e'(in_item_i.command))
            tdma_sts_pkg::CMD_SYNC: begin
              epoch_d     = in_item_i.time_ms - TW'(in_item_i.air_ms);
              last_sync_d = in_item_i.time_ms;
              known_d     = 1'b1;
              sync_d      = 1'b1;
            end
            tdma_sts_pkg::CMD_START: begin
              if (!known_q) begin
                epoch_d     = in_item_i.time_ms;
                last_sync_d = in_item_i.time_ms;
                known_d     = 1'b1;
                sync_d      = 1'b0;
              end
            end
            default: begin
              // tick or query; holdover expiry
              if (sync_q && (hold_diff > cfg.holdover_time)) begin
                sync_d = 1'b0;
              end
            end
          endcase
          state_d = tdma_sts_pkg::ST_MUL;
        end
      end
      tdma_sts_pkg::ST_MUL: begin
        prod_own_d = tdma_sts_pkg::ProdW'(cfg.own_slot) *
                     tdma_sts_pkg::ProdW'(cfg.slot_len);
        prod_cnt_d = tdma_sts_pkg::ProdW'(cfg.slot_count) *
                     tdma_sts_pkg::ProdW'(cfg.slot_len);
        state_d    = tdma_sts_pkg::ST_CHK;
      end
      tdma_sts_pkg::ST_CHK: begin
        bad_d = (cfg.slot_count == '0) || (cfg.own_slot >= cfg.slot_count) ||
                (cfg.slot_len == '0) || (cfg.superframe_len == '0) ||
                (TW'(cfg.superframe_len) > tdma_sts_pkg::SUPERFRAME_MAX) ||
                (TW'(need) > TW'(cfg.superframe_len));
        base_t_d = epoch_q + offset;
        d_b_d    = target_q - epoch_q;
        d_t_d    = target_q - (epoch_q + offset);
        if (bad_d || !known_q) begin
          state_d = tdma_sts_pkg::ST_OUT;
        end else begin
          state_d = tdma_sts_pkg::ST_GO_B;
        end
      end
      tdma_sts_pkg::ST_GO_B: begin
        rem_start = 1'b1;
        rem_dvd   = d_b_q;
        state_d   = tdma_sts_pkg::ST_DIV_B;
      end
      tdma_sts_pkg::ST_DIV_B: begin
        if (rem_done) begin
          bcn_d   = first_start(epoch_q, target_q, d_b_q, rem_val, cfg.superframe_len);
          state_d = tdma_sts_pkg::ST_GO_T;
        end
      end
      tdma_sts_pkg::ST_GO_T: begin
        rem_start = 1'b1;
        rem_dvd   = d_t_q;
        state_d   = tdma_sts_pkg::ST_DIV_T;
      end
      tdma_sts_pkg::ST_DIV_T: begin
        if (rem_done) begin
          tx_d    = first_start(base_t_q, target_q, d_t_q, rem_val, cfg.superframe_len);
          state_d = tdma_sts_pkg::ST_OUT;
        end
      end
      tdma_sts_pkg::ST_OUT: begin
        // hold here until the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_valid_d          = 1'b1;
          out_d.epoch_valid    = known_q;
          out_d.synced         = sync_q;
          out_d.config_invalid = bad_q;
          if (!known_q || bad_q) begin
            out_d.next_tx_ms     = '0;
            out_d.next_beacon_ms = '0;
          end else begin
            out_d.next_tx_ms     = tx_q;
            out_d.next_beacon_ms = bcn_q;
          end
          state_d = tdma_sts_pkg::ST_IDLE;
        end
      end
      default: state_d = tdma_sts_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tdma_sts_pkg::ST_IDLE;
      epoch_q     <= '0;
      last_sync_q <= '0;
      known_q     <= 1'b0;
      sync_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      epoch_q     <= epoch_d;
      last_sync_q <= last_sync_d;
      known_q     <= known_d;
      sync_q      <= sync_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    target_q   <= target_d;
    prod_own_q <= prod_own_d;
    prod_cnt_q <= prod_cnt_d;
    bad_q      <= bad_d;
    base_t_q   <= base_t_d;
    d_b_q      <= d_b_d;
    d_t_q      <= d_t_d;
    bcn_q      <= bcn_d;
    tx_q       <= tx_d;
    out_q      <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // sequencer only takes an item while the remainder unit is quiet
  a_ready_unit_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !rem_busy)
    else $error("input ready while remainder unit busy");

  a_one_item_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("ready did not drop after accepting an item");

  a_times_zero_when_unusable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (!out_item_o.epoch_valid || out_item_o.config_invalid)) |->
      (out_item_o.next_tx_ms == '0 && out_item_o.next_beacon_ms == '0))
    else $error("times not cleared for unusable result");

  a_synced_needs_epoch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sync_q |-> known_q)
    else $error("synced without a known epoch");

endmodule

/* test/tdma_slot_time_scheduler_tb.sv */
// Self-checking testbench for the TDMA slot time scheduler: directed and random events.
module tdma_slot_time_scheduler_tb;
  import tdma_sts_pkg::*;

  // Command 3 is not in the enum; the block treats it as a tick.
  localparam logic [1:0]         CMD_SPARE  = 2'd3;
  // Index 7 has no register behind it; a write there must change nothing.
  localparam logic [RegIdxW-1:0] REG_UNUSED = 3'd7;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned TAIL_CYCLES = 80;   // a bit more than the time one item takes through the block
  localparam int unsigned MAX_REPORTS = 10;

  localparam cfg_t CFG_DEFAULT = '{
    superframe_len: 30'd10000,
    slot_len:       16'd1000,
    beacon_len:     16'd1000,
    slot_count:     8'd8,
    own_slot:       8'd0,
    guard_time:     16'd50,
    holdover_time:  32'd60000
  };

  // ---------------------------------------------------------------------------
  // Clock, reset and block inputs (all known from time zero)
  // ---------------------------------------------------------------------------
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  in_item_t            in_item_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  out_item_t           out_item_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [RegIdxW-1:0]  cfg_index_i = '0;
  logic [TimeW-1:0]    cfg_data_i  = '0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  tdma_slot_time_scheduler dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // ---------------------------------------------------------------------------
  // Scheduler shadow: registers plus epoch / sync state
  // ---------------------------------------------------------------------------
  cfg_t        sched_cfg         = CFG_DEFAULT;
  logic [31:0] sched_epoch       = '0;
  logic [31:0] sched_last_sync   = '0;
  bit          sched_epoch_known = 1'b0;
  bit          sched_synced      = 1'b0;

  out_item_t   expected_sched_q[$];
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt    = 0;

  // Traffic shaping knobs
  bit          gaps_on   = 1'b1;
  int unsigned gap_pct   = 30;   // chance per item of a sender gap
  int unsigned stall_pct = 5;    // chance per cycle of a receiver stall burst
  int unsigned stall_left = 0;
  logic [31:0] cur_time  = '0;

  // Init rules of the scheduler; need is kept wide so a huge slot table can't wrap.
  function automatic bit cfg_rejected(cfg_t c);
    logic [63:0] need;
    need = 64'(c.beacon_len) + 64'(c.slot_count) * 64'(c.slot_len);
    return (c.slot_count == 0) || (c.own_slot >= c.slot_count) || (c.slot_len == 0) ||
           (c.superframe_len == 0) || ({2'b00, c.superframe_len} > SUPERFRAME_MAX) ||
           (need > 64'(c.superframe_len));
  endfunction

  // First epoch + offset + k * superframe that is not before now + guard.
  // A start behind the target by 2^31 or more counts as ahead (wrap-safe compare).
  function automatic logic [31:0] slot_start(logic [31:0] now, logic [31:0] offset);
    logic [31:0] base;
    logic [31:0] target;
    logic [31:0] lead;
    logic [63:0] periods;
    base   = sched_epoch + offset;
    target = now + 32'(sched_cfg.guard_time);
    lead   = target - base;
    if (lead == 0 || lead[31]) return base;
    periods = (64'(lead) + 64'(sched_cfg.superframe_len) - 64'd1) /
              64'(sched_cfg.superframe_len);
    return base + 32'(periods * 64'(sched_cfg.superframe_len));
  endfunction

  // Apply one accepted event to the shadow state and queue the expected item.
  task automatic predict_event(in_item_t ev);
    out_item_t r;
    bit        bad;
    bad = cfg_rejected(sched_cfg);
    case (ev.command)
      CMD_SYNC: begin
        sched_epoch       = ev.time_ms - 32'(ev.air_ms);
        sched_last_sync   = ev.time_ms;
        sched_epoch_known = 1'b1;
        sched_synced      = 1'b1;
      end
      CMD_START: begin
        // free-run start only seeds an epoch if none exists yet
        if (!sched_epoch_known) begin
          sched_epoch       = ev.time_ms;
          sched_last_sync   = ev.time_ms;
          sched_epoch_known = 1'b1;
          sched_synced      = 1'b0;
        end
      end
      default: begin
        // tick / query, the spare code included
        if (sched_synced && (ev.time_ms - sched_last_sync) > sched_cfg.holdover_time)
          sched_synced = 1'b0;
      end
    endcase
    r = '0;
    if (sched_epoch_known && !bad) begin
      r.next_tx_ms     = slot_start(ev.time_ms, 32'(sched_cfg.beacon_len) +
                                    32'(sched_cfg.own_slot) * 32'(sched_cfg.slot_len));
      r.next_beacon_ms = slot_start(ev.time_ms, 32'd0);
    end
    r.epoch_valid    = sched_epoch_known;
    r.synced         = sched_synced;
    r.config_invalid = bad;
    expected_sched_q.push_back(r);
  endtask

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  // Valid stays high with the last item after acceptance; the next call either
  // replaces it in the same step or drops valid for a gap.
  task automatic send_event(in_item_t ev);
    int unsigned gap;
    gap = 0;
    if (gaps_on && $urandom_range(0, 99) < gap_pct) gap = $urandom_range(1, 17);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_item_i  <= ev;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    predict_event(ev);
  endtask

  // Caller drops cfg_valid_i after the last write of a group.
  task automatic write_reg(logic [RegIdxW-1:0] idx, logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_SUPERFRAME: sched_cfg.superframe_len = data[SfW-1:0];
      REG_SLOT_LEN:   sched_cfg.slot_len       = data[LenW-1:0];
      REG_BEACON_LEN: sched_cfg.beacon_len     = data[LenW-1:0];
      REG_SLOT_COUNT: sched_cfg.slot_count     = data[CntW-1:0];
      REG_OWN_SLOT:   sched_cfg.own_slot       = data[CntW-1:0];
      REG_GUARD:      sched_cfg.guard_time     = data[LenW-1:0];
      REG_HOLDOVER:   sched_cfg.holdover_time  = data;
      default: ;
    endcase
  endtask

  task automatic apply_config(cfg_t c);
    write_reg(REG_SUPERFRAME, 32'(c.superframe_len));
    write_reg(REG_SLOT_LEN,   32'(c.slot_len));
    write_reg(REG_BEACON_LEN, 32'(c.beacon_len));
    write_reg(REG_SLOT_COUNT, 32'(c.slot_count));
    write_reg(REG_OWN_SLOT,   32'(c.own_slot));
    write_reg(REG_GUARD,      32'(c.guard_time));
    write_reg(REG_HOLDOVER,   c.holdover_time);
    cfg_valid_i <= 1'b0;
  endtask

  // Block is idle once its last item has been taken; a few spare cycles then.
  task automatic await_drain();
    in_valid_i <= 1'b0;
    while (expected_sched_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic in_item_t make_event(logic [1:0] cmd, logic [31:0] t, logic [15:0] air);
    in_item_t ev;
    ev.command = cmd;
    ev.time_ms = t;
    ev.air_ms  = air;
    return ev;
  endfunction

  // Valid layout with room to spare; one in five phases breaks a rule on purpose.
  function automatic cfg_t rand_valid_cfg(int unsigned step_max);
    cfg_t        c;
    logic [63:0] need;
    c.slot_count = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255))
                                               : 8'($urandom_range(1, 16));
    c.own_slot   = 8'($urandom_range(0, c.slot_count - 1));
    c.slot_len   = $urandom_range(0, 1) ? 16'($urandom_range(1, 65535))
                                        : 16'($urandom_range(1, 2000));
    c.beacon_len = 16'($urandom);
    need = 64'(c.beacon_len) + 64'(c.slot_count) * 64'(c.slot_len);
    c.superframe_len = 30'(need + 64'($urandom_range(0, 100000)));
    c.guard_time     = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 100));
    c.holdover_time  = $urandom_range(0, step_max * 6);
    if ($urandom_range(0, 4) == 0) begin
      case ($urandom_range(0, 4))
        0: c.slot_count     = '0;
        1: c.own_slot       = c.slot_count;
        2: c.slot_len       = '0;
        3: c.superframe_len = '0;
        default: c.superframe_len = 30'(need - 64'd1);
      endcase
    end
    return c;
  endfunction

  // Mostly time moving forward in steps, with the odd jump anywhere on the clock.
  task automatic run_events(int unsigned count, int unsigned step_max);
    in_item_t    ev;
    int unsigned pick;
    for (int unsigned i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 15)      ev.command = CMD_SYNC;
      else if (pick < 22) ev.command = CMD_START;
      else if (pick < 95) ev.command = CMD_TICK;
      else                ev.command = CMD_SPARE;
      if ($urandom_range(0, 19) == 0) cur_time = $urandom;
      else                            cur_time = cur_time + $urandom_range(0, step_max);
      ev.time_ms = cur_time;
      ev.air_ms  = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 200));
      send_event(ev);
    end
  endtask

  function automatic int unsigned pick_step();
    case ($urandom_range(0, 3))
      0:       return 50;
      1:       return 5000;
      2:       return 200000;
      default: return 50000000;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Event semantics at the reset register values.
  task automatic test_directed_events();
    gaps_on = 1'b1; gap_pct = 30; stall_pct = 5;
    send_event(make_event(CMD_TICK,  32'd0, 16'd0));              // no epoch: times zero
    send_event(make_event(CMD_SPARE, 32'hFFFF_FFFF, 16'hFFFF));   // spare code as tick
    send_event(make_event(CMD_START, 32'd1000, 16'hFFFF));        // seeds epoch 1000
    send_event(make_event(CMD_START, 32'd5000, 16'd0));           // epoch kept
    send_event(make_event(CMD_TICK,  32'd950, 16'd0));            // start exactly at target
    send_event(make_event(CMD_TICK,  32'd10950, 16'd0));          // exactly one period later
    send_event(make_event(CMD_TICK,  32'h8000_03E8, 16'd0));      // beacon base 2^31 behind: kept
    send_event(make_event(CMD_SYNC,  32'hFFFF_FF00, 16'hFFFF));   // sync near the top of the clock, maximum air time
    send_event(make_event(CMD_TICK,  32'hFFFF_FF00 + 32'd60000, 16'd0)); // at holdover: held
    send_event(make_event(CMD_TICK,  32'hFFFF_FF00 + 32'd60001, 16'd0)); // past it: drops
    send_event(make_event(CMD_SYNC,  32'd0, 16'd0));
    send_event(make_event(CMD_SPARE, 32'h7FFF_FFFF, 16'd0));      // long gap drops sync
    send_event(make_event(CMD_SYNC,  32'h8000_0000, 16'd1));
    send_event(make_event(CMD_TICK,  32'h8000_0000, 16'd0));
    await_drain();
  endtask

  task automatic probe_config(cfg_t c);
    apply_config(c);
    send_event(make_event(CMD_TICK, cur_time, 16'd0));
    await_drain();
  endtask

  // Each breakable init rule on its own, the exact-fit boundary, masking of
  // upper data bits and a write to the empty index.
  task automatic test_config_rules();
    cfg_t c;
    cur_time = 32'h8000_1234;
    c = CFG_DEFAULT; c.slot_count = '0;          probe_config(c);
    c = CFG_DEFAULT; c.own_slot = 8'd8;          probe_config(c);
    c = CFG_DEFAULT; c.slot_len = '0;            probe_config(c);
    c = CFG_DEFAULT; c.superframe_len = '0;      probe_config(c);
    c = CFG_DEFAULT; c.beacon_len = 16'd2001;    probe_config(c);  // one ms too long
    c = CFG_DEFAULT; c.beacon_len = 16'd2000;    probe_config(c);  // exact fit is fine
    c = CFG_DEFAULT; c.own_slot = 8'd7; c.guard_time = '0; probe_config(c);
    write_reg(REG_SUPERFRAME, 32'hC000_2710);    // only the low 30 bits count
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    cfg_valid_i <= 1'b0;
    send_event(make_event(CMD_TICK, cur_time, 16'd0));
    await_drain();
  endtask

  // Phases of random events, each under its own register setting and traffic.
  task automatic test_random_phases();
    cfg_t        c;
    logic [127:0] raw;
    int unsigned step_max;
    for (int p = 0; p < 11; p++) begin
      step_max = pick_step();
      case (p)
        0: c = '{superframe_len: 30'h3FFF_FFFF, slot_len: 16'hFFFF, beacon_len: 16'hFFFF,
                 slot_count: 8'hFF, own_slot: 8'hFE, guard_time: 16'hFFFF,
                 holdover_time: 32'hFFFF_FFFF};
        1: c = '{superframe_len: 30'd1, slot_len: 16'd1, beacon_len: 16'd0,
                 slot_count: 8'd1, own_slot: 8'd0, guard_time: 16'd0, holdover_time: 32'd0};
        2: begin
          raw = {$urandom, $urandom, $urandom, $urandom};
          c   = raw[$bits(cfg_t)-1:0];   // all fields random, mostly rejected
        end
        3: c = '{superframe_len: 30'd16777215, slot_len: 16'hFFFF, beacon_len: 16'hFFFF,
                 slot_count: 8'hFF, own_slot: 8'hFE, guard_time: 16'd0,
                 holdover_time: 32'(step_max * 3)};
        default: c = rand_valid_cfg(step_max);
      endcase
      apply_config(c);
      case ($urandom_range(0, 2))
        0:       begin gap_pct = 0;  stall_pct = 0;  end
        1:       begin gap_pct = 30; stall_pct = 4;  end
        default: begin gap_pct = 70; stall_pct = 15; end
      endcase
      run_events(75, step_max);
      await_drain();
    end
  endtask

  // Closing stretch at full rate on both sides.
  task automatic test_steady_run();
    int unsigned step_max;
    gaps_on  = 1'b0;
    step_max = pick_step();
    apply_config(rand_valid_cfg(step_max));
    run_events(75, step_max);
    await_drain();
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: ready drops in bursts, each started by a random draw on non-stall cycles
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left  <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else if (gaps_on && $urandom_range(0, 99) < stall_pct) begin
      stall_left  <= $urandom_range(0, 16);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: each taken item against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : result_check
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_sched_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS)
          $display("unexpected item: tx=%h bcn=%h ev=%b sy=%b ci=%b",
                   out_item_o.next_tx_ms, out_item_o.next_beacon_ms,
                   out_item_o.epoch_valid, out_item_o.synced, out_item_o.config_invalid);
      end else begin
        want = expected_sched_q.pop_front();
        if (out_item_o.next_tx_ms     !== want.next_tx_ms     ||
            out_item_o.next_beacon_ms !== want.next_beacon_ms ||
            out_item_o.epoch_valid    !== want.epoch_valid    ||
            out_item_o.synced         !== want.synced         ||
            out_item_o.config_invalid !== want.config_invalid) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS)
            $display({"mismatch: exp tx=%h bcn=%h ev=%b sy=%b ci=%b",
                      " | got tx=%h bcn=%h ev=%b sy=%b ci=%b"},
                     want.next_tx_ms, want.next_beacon_ms, want.epoch_valid,
                     want.synced, want.config_invalid,
                     out_item_o.next_tx_ms, out_item_o.next_beacon_ms,
                     out_item_o.epoch_valid, out_item_o.synced, out_item_o.config_invalid);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_events();
    test_config_rules();
    test_random_phases();
    test_steady_run();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0 && expected_sched_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/tdma_sts_pkg.sv
rtl/tdma_sts_cfg.sv
rtl/tdma_sts_rem.sv
rtl/tdma_slot_time_scheduler.sv
test/tdma_slot_time_scheduler_tb.sv
